/* sv/iira_pkg.sv */
`default_nettype none
package iira_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_PUSH   = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_POP    = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_WRITE  = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  pos;
        logic [WORD_W-1:0] value;
        logic [IDX_W-1:0]  rd_pos;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* sv/iira_cell.sv */
`default_nettype none
module iira_cell
    import iira_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [IDX_W-1:0]  i_pos,
    input  wire logic [WORD_W-1:0] i_left_word,
    input  wire logic [WORD_W-1:0] i_right_word,
    output logic      [WORD_W-1:0] o_word,
    output logic      [WORD_W-1:0] o_read
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_word = r_word;
            end
            CELL_WRITE: begin
                if (i_pos == i_ctl.pos) begin
                    n_word = i_ctl.value;
                end
            end
            CELL_INSERT: begin
                if (i_pos > i_ctl.pos) begin
                    n_word = i_left_word;
                end else if (i_pos == i_ctl.pos) begin
                    n_word = i_ctl.value;
                end
            end
            CELL_REMOVE: begin
                if (i_pos >= i_ctl.pos) begin
                    n_word = i_right_word;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_read = (i_pos == i_ctl.rd_pos) ? r_word : '0;

endmodule
`default_nettype wire

/* sv/iira_chain.sv */
`default_nettype none
module iira_chain
    import iira_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    output logic      [WORD_W-1:0] o_read
);

    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_read [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] w_left;
        logic [WORD_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_left
            assign w_left = w_word[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_word[k];
        end else begin : g_inner_right
            assign w_right = w_word[k+1];
        end

        iira_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_pos        (IDX_W'(k)),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .o_word       (w_word[k]),
            .o_read       (w_read[k])
        );
    end

    always_comb begin
        o_read = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_read = o_read | w_read[k];
        end
    end

endmodule
`default_nettype wire

/* sv/indexed_insert_remove_array.sv */
`default_nettype none
// Ordered store of up to DEPTH signed 32-bit words held in a chain of cells, one word per
// cell. Each input transaction carries a command (read, push, insert, pop, remove, clear) and
// produces exactly one result transaction with the word read, the new count and a status.
// All cells shift towards their neighbours at once, so one transaction is accepted per clock
// while o_stall is low; the result is registered, in the output register or, when that one
// holds a stalled result, in a skid entry. A two-entry output buffer lets input be taken while
// a result waits, and the input stalls only when both entries are occupied.
module indexed_insert_remove_array
    import iira_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_command,
    input  wire logic [4:0]         i_index,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_read_data,
    output logic [5:0]              o_count,
    output logic [1:0]              o_status
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [1:0]       w_status;
    logic [31:0]      w_rd;
    logic [31:0]      w_chain_read;
    logic             w_accept;
    logic             w_in_range;
    logic             w_full;
    t_cell_ctl        w_ctl;

    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic [5:0]       r_out_count;
    logic [1:0]       r_out_status;
    logic             r_skid_valid;
    logic [31:0]      r_skid_data;
    logic [5:0]       r_skid_count;
    logic [1:0]       r_skid_status;

    assign w_accept   = i_valid && !r_skid_valid;
    assign w_in_range = 32'(i_index) < 32'(r_count);
    assign w_full     = 32'(r_count) >= 32'(DEPTH);

    always_comb begin
        n_count      = r_count;
        w_status     = ST_OK;
        w_rd         = '0;
        w_ctl.op     = CELL_HOLD;
        w_ctl.pos    = IDX_W'(i_index);
        w_ctl.value  = i_value;
        w_ctl.rd_pos = IDX_W'(i_index);
        unique case (i_command)
            CMD_READ: begin
                if (w_in_range) begin
                    w_rd = w_chain_read;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            CMD_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.op  = CELL_WRITE;
                    w_ctl.pos = IDX_W'(r_count);
                    n_count   = r_count + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.op = CELL_REMOVE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!w_accept) begin
            w_ctl.op = CELL_HOLD;
        end
    end

    iira_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_read (w_chain_read)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                end
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_out_count  <= r_skid_count;
                r_out_status <= r_skid_status;
            end else begin
                r_out_data   <= w_rd;
                r_out_count  <= 6'(n_count);
                r_out_status <= w_status;
            end
        end else if (w_accept) begin
            r_skid_data   <= w_rd;
            r_skid_count  <= 6'(n_count);
            r_skid_status <= w_status;
        end
    end

    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
module tb;
    import iira_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int STAGE_ITEMS     = 120;
    localparam int HOLD_ITEMS      = 60;
    localparam int MAX_PRINTED     = 50;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        STAGE_DIRECTED,
        STAGE_FREE,
        STAGE_SEND_IDLE,
        STAGE_RECV_STALL,
        STAGE_BOTH,
        STAGE_HOLD,
        STAGE_DRAIN
    } t_stage;

    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_SHRINK,
        MODE_NOISE
    } t_build_mode;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_data;
        logic [CNT_W-1:0]         count;
        logic [1:0]               status;
    } t_array_result;

    typedef struct {
        logic [2:0]               command;
        logic [IDX_W-1:0]         index;
        logic signed [WORD_W-1:0] value;
        bit                       pinned;
        t_array_result            outcome;
    } t_array_command;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [2:0]               i_command = CMD_READ;
    logic [4:0]               i_index = '0;
    logic signed [31:0]       i_value = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [31:0]       o_read_data;
    logic [5:0]               o_count;
    logic [1:0]               o_status;

    t_stage                   stage = STAGE_DIRECTED;
    int                       hold_count = 0;
    int                       idle_cycles = 0;
    int                       mismatches = 0;

    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    logic [CNT_W-1:0]         shadow_count = '0;
    t_array_result            pending_results [$];
    t_array_command           directed_rows [$];

    indexed_insert_remove_array i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_data (o_read_data),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic apply_command(input logic [2:0] command, input logic [IDX_W-1:0] index,
                                 input logic signed [WORD_W-1:0] value,
                                 output t_array_result outcome);
        outcome = '0;
        case (command)
            CMD_READ: begin
                if (index < shadow_count) begin
                    outcome.read_data = shadow_words[index];
                end else begin
                    outcome.status = ST_RANGE;
                end
            end
            CMD_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = value;
                    shadow_count++;
                end
            end
            CMD_INSERT: begin
                if (index >= shadow_count) begin
                    outcome.status = ST_RANGE;
                end else if (shadow_count >= DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    for (int k = shadow_count; k > index; k--) begin
                        shadow_words[k] = shadow_words[k-1];
                    end
                    shadow_words[index] = value;
                    shadow_count++;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0) begin
                    outcome.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                end
            end
            CMD_REMOVE: begin
                if (index >= shadow_count) begin
                    outcome.status = ST_RANGE;
                end else begin
                    for (int k = index; k + 1 < shadow_count; k++) begin
                        shadow_words[k] = shadow_words[k+1];
                    end
                    shadow_count--;
                end
            end
            CMD_CLEAR: begin
                shadow_count = '0;
            end
            default: begin
            end
        endcase
        outcome.count = shadow_count;
    endtask

    task automatic add_row(input logic [2:0] command, input logic [IDX_W-1:0] index,
                           input logic signed [WORD_W-1:0] value, input bit pinned,
                           input logic signed [WORD_W-1:0] read_data,
                           input logic [CNT_W-1:0] count, input logic [1:0] status);
        t_array_command row;
        row.command = command;
        row.index = index;
        row.value = value;
        row.pinned = pinned;
        row.outcome.read_data = read_data;
        row.outcome.count = count;
        row.outcome.status = status;
        directed_rows = {directed_rows, row};
    endtask

    task automatic send_command(input t_array_command row);
        t_array_result predicted;
        int gap_percent;
        gap_percent = (stage == STAGE_SEND_IDLE) ? 82 : (stage == STAGE_BOTH) ? 13 : 0;
        if (gap_percent > 0 && $urandom_range(99) < gap_percent) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_percent);
        end
        i_valid <= 1'b1;
        i_command <= row.command;
        i_index <= row.index;
        i_value <= row.value;
        do @(posedge i_clk); while (o_stall);
        apply_command(row.command, row.index, row.value, predicted);
        if (row.pinned) begin
            predicted = row.outcome;
        end
        pending_results = {pending_results, predicted};
    endtask

    function automatic t_array_command random_command(input t_build_mode mode);
        t_array_command row;
        int pick;
        row.pinned = 1'b0;
        row.outcome = '0;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: row.value = WORD_MAX;
                1: row.value = WORD_MIN;
                2: row.value = '0;
                default: row.value = -1;
            endcase
        end else begin
            row.value = $urandom;
        end
        if (shadow_count > 0 && $urandom_range(9) != 0) begin
            row.index = IDX_W'($urandom_range(shadow_count - 1));
        end else begin
            row.index = IDX_W'($urandom_range(DEPTH - 1));
        end
        pick = $urandom_range(99);
        case (mode)
            MODE_GROW: begin
                row.command = (pick < 55) ? CMD_PUSH : (pick < 90) ? CMD_INSERT : CMD_READ;
            end
            MODE_SHRINK: begin
                row.command = (pick < 40) ? CMD_POP : (pick < 80) ? CMD_REMOVE : CMD_READ;
            end
            default: begin
                if (pick < 10) begin
                    row.command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
                end else if (pick < 13) begin
                    row.command = CMD_CLEAR;
                end else begin
                    row.command = 3'($urandom_range(CMD_REMOVE, CMD_READ));
                end
            end
        endcase
        return row;
    endfunction

    task automatic run_stage(input t_stage which, input int items);
        int sent;
        int run_length;
        int pick;
        t_build_mode mode;
        stage = which;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                mode = MODE_GROW;
                run_length = DEPTH - shadow_count + $urandom_range(4, 2);
            end else if (pick < 75) begin
                mode = MODE_SHRINK;
                run_length = shadow_count + $urandom_range(4, 2);
            end else begin
                mode = MODE_NOISE;
                run_length = $urandom_range(12, 4);
            end
            repeat (run_length) begin
                send_command(random_command(mode));
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stage == STAGE_HOLD && hold_count < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            case (stage)
                STAGE_RECV_STALL: i_stall <= ($urandom_range(99) < 82);
                STAGE_BOTH:       i_stall <= ($urandom_range(99) < 13);
                default:          i_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_array_result wanted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with no command outstanding");
                end else begin
                    wanted = pending_results.pop_front();
                    if (o_read_data !== wanted.read_data) begin
                        report_mismatch($sformatf("read_data %0d, expected %0d",
                                                  o_read_data, wanted.read_data));
                    end
                    if (o_count !== wanted.count) begin
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  o_count, wanted.count));
                    end
                    if (o_status !== wanted.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, wanted.status));
                    end
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("indexed_insert_remove_array test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(CMD_READ,   0,  0,        1, 0,        0, ST_RANGE);
        add_row(CMD_POP,    0,  0,        1, 0,        0, ST_EMPTY);
        add_row(CMD_REMOVE, 0,  0,        1, 0,        0, ST_RANGE);
        add_row(CMD_INSERT, 0,  5,        1, 0,        0, ST_RANGE);
        add_row(CMD_PUSH,   31, WORD_MAX, 1, 0,        1, ST_OK);
        add_row(CMD_PUSH,   0,  WORD_MIN, 1, 0,        2, ST_OK);
        add_row(CMD_READ,   0,  -1,       1, WORD_MAX, 2, ST_OK);
        add_row(CMD_READ,   1,  0,        1, WORD_MIN, 2, ST_OK);
        add_row(CMD_READ,   31, 0,        1, 0,        2, ST_RANGE);
        add_row(CMD_INSERT, 1,  -1,       0, 0,        0, ST_OK);
        add_row(CMD_INSERT, 0,  0,        0, 0,        0, ST_OK);
        add_row(CMD_READ,   0,  0,        0, 0,        0, ST_OK);
        add_row(CMD_READ,   1,  0,        0, 0,        0, ST_OK);
        add_row(CMD_READ,   2,  0,        0, 0,        0, ST_OK);
        add_row(CMD_READ,   3,  0,        0, 0,        0, ST_OK);
        add_row(CMD_REMOVE, 31, 0,        0, 0,        0, ST_OK);
        add_row(CMD_REMOVE, 1,  0,        0, 0,        0, ST_OK);
        add_row(CMD_SPARE_LO, 31, -1,     0, 0,        0, ST_OK);
        add_row(CMD_SPARE_HI, 0,  WORD_MIN, 0, 0,      0, ST_OK);
        add_row(CMD_READ,   2,  0,        0, 0,        0, ST_OK);
        add_row(CMD_POP,    0,  0,        0, 0,        0, ST_OK);
        add_row(CMD_CLEAR,  0,  0,        1, 0,        0, ST_OK);
        add_row(CMD_READ,   0,  0,        1, 0,        0, ST_RANGE);
        foreach (directed_rows[n]) begin
            send_command(directed_rows[n]);
        end

        run_stage(STAGE_FREE, STAGE_ITEMS);
        run_stage(STAGE_SEND_IDLE, STAGE_ITEMS);
        run_stage(STAGE_RECV_STALL, STAGE_ITEMS);
        run_stage(STAGE_HOLD, HOLD_ITEMS);
        run_stage(STAGE_BOTH, STAGE_ITEMS);
        stage = STAGE_DRAIN;
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("indexed_insert_remove_array test passed");
        end else begin
            $display("indexed_insert_remove_array test failed");
        end
        $finish;
    end

endmodule
